// ===== src/dppt_pkg.sv =====
package dppt_pkg;

    // default sizes of the stores
    localparam int INDEX_ENTRIES_DEF = 256;
    localparam int PACKAGE_SLOTS_DEF = 32;
    localparam int FOOTPRINT_MAX_DEF = 64;

    // field widths
    localparam int REQ_W       = 2;
    localparam int TXID_W      = 256;
    localparam int POS_W       = 32;
    localparam int KEY_W       = TXID_W + POS_W;
    localparam int WEIGHT_W    = 32;
    localparam int VALUE_W     = 48;
    localparam int SEQ_W       = 64;
    localparam int TOTAL_W     = 40;
    localparam int EVICT_W     = 32;
    localparam int PKG_COUNT_W = 6;
    localparam int STATUS_W    = 3;
    localparam int IN_DATA_W   = 368;
    localparam int OUT_DATA_W  = 160;

    localparam logic [TOTAL_W-1:0] MAX_WEIGHT_RST = 40'd4000000;

    // request kinds
    localparam logic [REQ_W-1:0] REQ_PARK   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_FIND   = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE      = 3'd0,
        ST_CONFLICT  = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_CAPACITY  = 3'd3,
        ST_STAGED    = 3'd4
    } t_status;

    // datapath operations
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_ILOOK,
        OP_CONF,
        OP_SLOOK,
        OP_STAGE,
        OP_FREESLOT,
        OP_ALLOC,
        OP_INS_RD,
        OP_INS,
        OP_VSCAN,
        OP_VTAKE,
        OP_SREAD,
        OP_SGOT,
        OP_DROP,
        OP_DROP_END,
        OP_FINISH
    } t_op;

    typedef struct packed {
        t_op     op;
        logic    clr;
        t_status status;
    } t_cmd;

    typedef struct packed {
        logic [REQ_W-1:0] rq;
        logic             last;
        logic             hit;
        logic             scan_end;
        logic             conflict;
        logic             overflow;
        logic             idx_room;
        logic             slot_end;
        logic             ins_wrote;
        logic             k_last;
        logic             over_cap;
        logic             best_ok;
        logic             out_free;
    } t_stat;

endpackage

// ===== src/dppt_ram.sv =====
module dppt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/dppt_ctrl.sv =====
module dppt_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  dppt_pkg::t_stat i_stat,
    output dppt_pkg::t_cmd  o_cmd
);
    import dppt_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE,
        S_ILOOK,
        S_CONF,
        S_SLOOK,
        S_STAGE,
        S_COMMIT,
        S_FREESLOT,
        S_ALLOC,
        S_INS_RD,
        S_INS,
        S_EVCHK,
        S_VSCAN,
        S_VTAKE,
        S_DROP,
        S_DROP_END,
        S_SREAD,
        S_SGOT,
        S_DONE
    } t_state;

    t_state  r_state, n_state;
    t_status r_status, n_status;
    logic    rq_known;

    assign rq_known = (i_stat.rq == REQ_PARK) || (i_stat.rq == REQ_REMOVE) ||
                      (i_stat.rq == REQ_FIND);

    // next state and command
    always_comb begin
        n_state      = r_state;
        n_status     = r_status;
        o_cmd.op     = OP_NONE;
        o_cmd.clr    = 1'b0;
        o_cmd.status = r_status;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op  = OP_LOAD;
                    o_cmd.clr = 1'b1;
                    n_state   = S_ILOOK;
                end
            end
            S_ILOOK: begin
                o_cmd.op = OP_ILOOK;
                if (!rq_known) begin
                    n_status = ST_NOT_FOUND;
                    n_state  = S_DONE;
                end else if (i_stat.hit || i_stat.scan_end) begin
                    if (i_stat.rq == REQ_PARK) begin
                        n_state = S_CONF;
                    end else if (i_stat.hit) begin
                        n_state = S_SREAD;
                    end else begin
                        n_status = ST_NOT_FOUND;
                        n_state  = S_DONE;
                    end
                end
            end
            S_CONF: begin
                o_cmd.op  = OP_CONF;
                o_cmd.clr = 1'b1;
                n_state   = S_SLOOK;
            end
            S_SLOOK: begin
                o_cmd.op = OP_SLOOK;
                if (i_stat.hit || i_stat.scan_end) begin
                    n_state = S_STAGE;
                end
            end
            S_STAGE: begin
                o_cmd.op = OP_STAGE;
                if (i_stat.last) begin
                    n_state = S_COMMIT;
                end else begin
                    n_status = ST_STAGED;
                    n_state  = S_DONE;
                end
            end
            S_COMMIT: begin
                o_cmd.clr = 1'b1;
                if (i_stat.conflict) begin
                    n_status = ST_CONFLICT;
                    n_state  = S_DONE;
                end else if (i_stat.overflow || !i_stat.idx_room) begin
                    n_status = ST_CAPACITY;
                    n_state  = S_DONE;
                end else begin
                    n_state = S_FREESLOT;
                end
            end
            S_FREESLOT: begin
                o_cmd.op = OP_FREESLOT;
                if (i_stat.hit) begin
                    n_state = S_ALLOC;
                end else if (i_stat.slot_end) begin
                    n_status = ST_CAPACITY;
                    n_state  = S_DONE;
                end
            end
            S_ALLOC: begin
                o_cmd.op  = OP_ALLOC;
                o_cmd.clr = 1'b1;
                n_state   = S_INS_RD;
            end
            S_INS_RD: begin
                o_cmd.op = OP_INS_RD;
                n_state  = S_INS;
            end
            S_INS: begin
                o_cmd.op = OP_INS;
                if (i_stat.ins_wrote) begin
                    n_state = i_stat.k_last ? S_EVCHK : S_INS_RD;
                end
            end
            S_EVCHK: begin
                o_cmd.clr = 1'b1;
                if (i_stat.over_cap) begin
                    n_state = S_VSCAN;
                end else begin
                    n_status = ST_DONE;
                    n_state  = S_DONE;
                end
            end
            S_VSCAN: begin
                o_cmd.op = OP_VSCAN;
                if (i_stat.scan_end) begin
                    n_state = S_VTAKE;
                end
            end
            S_VTAKE: begin
                if (i_stat.best_ok) begin
                    o_cmd.op  = OP_VTAKE;
                    o_cmd.clr = 1'b1;
                    n_state   = S_DROP;
                end else begin
                    n_status = ST_DONE;
                    n_state  = S_DONE;
                end
            end
            S_DROP: begin
                o_cmd.op = OP_DROP;
                if (i_stat.scan_end) begin
                    n_state = S_DROP_END;
                end
            end
            S_DROP_END: begin
                o_cmd.op = OP_DROP_END;
                if (i_stat.rq == REQ_PARK) begin
                    n_state = S_EVCHK;
                end else begin
                    n_status = ST_DONE;
                    n_state  = S_DONE;
                end
            end
            S_SREAD: begin
                o_cmd.op = OP_SREAD;
                n_state  = S_SGOT;
            end
            S_SGOT: begin
                o_cmd.op = OP_SGOT;
                if (i_stat.rq == REQ_FIND) begin
                    n_status = ST_DONE;
                    n_state  = S_DONE;
                end else begin
                    o_cmd.clr = 1'b1;
                    n_state   = S_DROP;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.op = OP_FINISH;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and result code
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_status <= ST_DONE;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

// ===== src/dppt_dp.sv =====
module dppt_dp #(
    parameter int INDEX_ENTRIES = dppt_pkg::INDEX_ENTRIES_DEF,
    parameter int PACKAGE_SLOTS = dppt_pkg::PACKAGE_SLOTS_DEF,
    parameter int FOOTPRINT_MAX = dppt_pkg::FOOTPRINT_MAX_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  dppt_pkg::t_cmd                     i_cmd,
    output dppt_pkg::t_stat                    o_stat,
    input  logic [dppt_pkg::REQ_W-1:0]         i_req_type,
    input  logic [dppt_pkg::TXID_W-1:0]        i_txid,
    input  logic [dppt_pkg::POS_W-1:0]         i_out_position,
    input  logic                               i_last_input,
    input  logic [dppt_pkg::WEIGHT_W-1:0]      i_pkg_weight,
    input  logic [dppt_pkg::VALUE_W-1:0]       i_pkg_value,
    input  logic                               i_cfg_valid,
    input  logic [dppt_pkg::TOTAL_W-1:0]       i_cfg_data,
    input  logic                               i_out_ready,
    output logic                               o_out_valid,
    output dppt_pkg::t_status                  o_status,
    output logic [dppt_pkg::WEIGHT_W-1:0]      o_found_weight,
    output logic [dppt_pkg::VALUE_W-1:0]       o_found_value,
    output logic [dppt_pkg::PKG_COUNT_W-1:0]   o_package_count,
    output logic [dppt_pkg::TOTAL_W-1:0]       o_total_weight,
    output logic [dppt_pkg::EVICT_W-1:0]       o_evicted_total
);
    import dppt_pkg::*;

    localparam int IDX_W   = $clog2(INDEX_ENTRIES);
    localparam int ICNT_W  = $clog2(INDEX_ENTRIES + 1);
    localparam int SLOT_W  = $clog2(PACKAGE_SLOTS);
    localparam int SCNT_W  = $clog2(PACKAGE_SLOTS + 1);
    localparam int FP_W    = (FOOTPRINT_MAX > 1) ? $clog2(FOOTPRINT_MAX) : 1;
    localparam int FCNT_W  = $clog2(FOOTPRINT_MAX + 1);
    localparam int MAX_NS  = (INDEX_ENTRIES > PACKAGE_SLOTS) ? INDEX_ENTRIES : PACKAGE_SLOTS;
    localparam int MAX_D   = (MAX_NS > FOOTPRINT_MAX) ? MAX_NS : FOOTPRINT_MAX;
    localparam int CNT_W   = $clog2(MAX_D + 1);
    localparam int IWORD_W = KEY_W + SLOT_W;
    localparam int SWORD_W = WEIGHT_W + VALUE_W + SEQ_W;

    // captured item
    logic [REQ_W-1:0]    r_rq;
    logic [KEY_W-1:0]    r_key;
    logic                r_last;
    logic [WEIGHT_W-1:0] r_w;
    logic [VALUE_W-1:0]  r_v;
    logic [TOTAL_W-1:0]  r_max_weight;

    // scan engine
    logic [CNT_W-1:0]  r_cnt, r_ra, lim;
    logic              r_rv, r_hit;
    logic [SLOT_W-1:0] r_owner, r_slot;
    logic [FCNT_W-1:0] r_k;

    // table state
    logic [INDEX_ENTRIES-1:0] r_ivalid;
    logic [PACKAGE_SLOTS-1:0] r_svalid;
    logic [ICNT_W-1:0]        r_icount;
    logic [SCNT_W-1:0]        r_pkg_cnt;
    logic [FCNT_W-1:0]        r_stage_cnt;
    logic                     r_conf, r_ovf;
    logic [TOTAL_W-1:0]       r_wsum;
    logic [SEQ_W-1:0]         r_seq;
    logic [EVICT_W-1:0]       r_evict;

    // eviction candidate
    logic                r_best_ok;
    logic [VALUE_W-1:0]  r_best_v;
    logic [SEQ_W-1:0]    r_best_seq;
    logic [WEIGHT_W-1:0] r_best_w;
    logic [SLOT_W-1:0]   r_best_slot;

    // result register
    logic                   r_ovalid;
    t_status                r_ostatus;
    logic [WEIGHT_W-1:0]    r_fw;
    logic [VALUE_W-1:0]     r_fv;
    logic [WEIGHT_W-1:0]    r_ofw;
    logic [VALUE_W-1:0]     r_ofv;
    logic [PKG_COUNT_W-1:0] r_ocount;
    logic [TOTAL_W-1:0]     r_ototal;
    logic [EVICT_W-1:0]     r_oevict;

    // memory ports
    logic [IWORD_W-1:0] idx_rdata;
    logic [KEY_W-1:0]   stg_rdata;
    logic [SWORD_W-1:0] slot_rdata;
    logic               idx_re, idx_we, stg_re, stg_we, slot_re;
    logic [FP_W-1:0]    stg_raddr;
    logic [SLOT_W-1:0]  slot_raddr;

    logic               scanning, rd_issue;
    logic [IDX_W-1:0]   cnt_i, ra_i;
    logic [SLOT_W-1:0]  cnt_s, ra_s, idx_owner;
    logic [WEIGHT_W-1:0] cand_w;
    logic [VALUE_W-1:0]  cand_v;
    logic [SEQ_W-1:0]    cand_seq;
    logic                cand_better;
    logic [ICNT_W-1:0]   idx_free;

    assign cnt_i     = r_cnt[IDX_W-1:0];
    assign ra_i      = r_ra[IDX_W-1:0];
    assign cnt_s     = r_cnt[SLOT_W-1:0];
    assign ra_s      = r_ra[SLOT_W-1:0];
    assign idx_owner = idx_rdata[KEY_W +: SLOT_W];
    assign cand_w    = slot_rdata[WEIGHT_W-1:0];
    assign cand_v    = slot_rdata[WEIGHT_W +: VALUE_W];
    assign cand_seq  = slot_rdata[WEIGHT_W+VALUE_W +: SEQ_W];
    assign idx_free  = ICNT_W'(INDEX_ENTRIES) - r_icount;

    // scan bound for the running sweep
    always_comb begin
        scanning = 1'b1;
        case (i_cmd.op) inside
            OP_ILOOK, OP_DROP: lim = CNT_W'(INDEX_ENTRIES);
            OP_SLOOK:          lim = CNT_W'(r_stage_cnt);
            OP_VSCAN:          lim = CNT_W'(PACKAGE_SLOTS);
            default: begin
                lim      = '0;
                scanning = 1'b0;
            end
        endcase
    end

    assign rd_issue = scanning && (r_cnt < lim);

    // lower value wins, older sequence on equal value
    assign cand_better = !r_best_ok || (cand_v < r_best_v) ||
                         ((cand_v == r_best_v) && (cand_seq < r_best_seq));

    // memory control
    assign idx_re     = rd_issue && ((i_cmd.op == OP_ILOOK) || (i_cmd.op == OP_DROP));
    assign idx_we     = (i_cmd.op == OP_INS) && !r_ivalid[cnt_i];
    assign stg_re     = (i_cmd.op == OP_INS_RD) || (rd_issue && (i_cmd.op == OP_SLOOK));
    assign stg_raddr  = (i_cmd.op == OP_INS_RD) ? r_k[FP_W-1:0] : r_cnt[FP_W-1:0];
    assign stg_we     = (i_cmd.op == OP_STAGE) && !r_hit &&
                        (r_stage_cnt < FCNT_W'(FOOTPRINT_MAX));
    assign slot_re    = (i_cmd.op == OP_SREAD) || (rd_issue && (i_cmd.op == OP_VSCAN));
    assign slot_raddr = (i_cmd.op == OP_SREAD) ? r_owner : cnt_s;

    dppt_ram #(.WIDTH(IWORD_W), .DEPTH(INDEX_ENTRIES)) u_index (
        .i_clk   (i_clk),
        .i_we    (idx_we),
        .i_waddr (cnt_i),
        .i_wdata ({r_slot, stg_rdata}),
        .i_re    (idx_re),
        .i_raddr (cnt_i),
        .o_rdata (idx_rdata)
    );

    dppt_ram #(.WIDTH(KEY_W), .DEPTH(FOOTPRINT_MAX)) u_stage (
        .i_clk   (i_clk),
        .i_we    (stg_we),
        .i_waddr (r_stage_cnt[FP_W-1:0]),
        .i_wdata (r_key),
        .i_re    (stg_re),
        .i_raddr (stg_raddr),
        .o_rdata (stg_rdata)
    );

    dppt_ram #(.WIDTH(SWORD_W), .DEPTH(PACKAGE_SLOTS)) u_slot (
        .i_clk   (i_clk),
        .i_we    (i_cmd.op == OP_ALLOC),
        .i_waddr (r_slot),
        .i_wdata ({r_seq, r_v, r_w}),
        .i_re    (slot_re),
        .i_raddr (slot_raddr),
        .o_rdata (slot_rdata)
    );

    // registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_weight <= MAX_WEIGHT_RST;
            r_cnt        <= '0;
            r_rv         <= 1'b0;
            r_hit        <= 1'b0;
            r_k          <= '0;
            r_ivalid     <= '0;
            r_svalid     <= '0;
            r_icount     <= '0;
            r_pkg_cnt    <= '0;
            r_stage_cnt  <= '0;
            r_conf       <= 1'b0;
            r_ovf        <= 1'b0;
            r_wsum       <= '0;
            r_seq        <= '0;
            r_evict      <= '0;
            r_best_ok    <= 1'b0;
            r_ovalid     <= 1'b0;
            r_rq         <= REQ_PARK;
            r_last       <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_max_weight <= i_cfg_data;
            end
            if (i_cmd.op == OP_FINISH) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
            r_rv <= rd_issue;
            if (i_cmd.clr) begin
                r_cnt     <= '0;
                r_hit     <= 1'b0;
                r_best_ok <= 1'b0;
            end
            if (scanning) begin
                r_ra <= r_cnt;
                if (rd_issue) begin
                    r_cnt <= r_cnt + CNT_W'(1);
                end
            end
            case (i_cmd.op)
                OP_LOAD: begin
                    r_rq   <= i_req_type;
                    r_key  <= {i_out_position, i_txid};
                    r_last <= i_last_input;
                    r_w    <= i_pkg_weight;
                    r_v    <= i_pkg_value;
                    r_fw   <= '0;
                    r_fv   <= '0;
                end
                OP_ILOOK: begin
                    if (r_rv && !r_hit && r_ivalid[ra_i] &&
                        (idx_rdata[KEY_W-1:0] == r_key)) begin
                        r_hit   <= 1'b1;
                        r_owner <= idx_owner;
                    end
                end
                OP_CONF: begin
                    r_conf <= r_conf | r_hit;
                end
                OP_SLOOK: begin
                    if (r_rv && !r_hit && (stg_rdata == r_key)) begin
                        r_hit <= 1'b1;
                    end
                end
                OP_STAGE: begin
                    if (!r_hit) begin
                        if (r_stage_cnt < FCNT_W'(FOOTPRINT_MAX)) begin
                            r_stage_cnt <= r_stage_cnt + FCNT_W'(1);
                        end else begin
                            r_ovf <= 1'b1;
                        end
                    end
                end
                OP_FREESLOT: begin
                    if (!r_hit && (r_cnt < CNT_W'(PACKAGE_SLOTS))) begin
                        if (!r_svalid[cnt_s]) begin
                            r_hit  <= 1'b1;
                            r_slot <= cnt_s;
                        end else begin
                            r_cnt <= r_cnt + CNT_W'(1);
                        end
                    end
                end
                OP_ALLOC: begin
                    r_svalid[r_slot] <= 1'b1;
                    r_pkg_cnt        <= r_pkg_cnt + SCNT_W'(1);
                    r_seq            <= r_seq + SEQ_W'(1);
                    r_wsum           <= r_wsum + TOTAL_W'(r_w);
                    r_k              <= '0;
                end
                OP_INS: begin
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (!r_ivalid[cnt_i]) begin
                        r_ivalid[cnt_i] <= 1'b1;
                        r_icount        <= r_icount + ICNT_W'(1);
                        r_k             <= r_k + FCNT_W'(1);
                    end
                end
                OP_VSCAN: begin
                    if (r_rv && r_svalid[ra_s] && cand_better) begin
                        r_best_ok   <= 1'b1;
                        r_best_v    <= cand_v;
                        r_best_seq  <= cand_seq;
                        r_best_w    <= cand_w;
                        r_best_slot <= ra_s;
                    end
                end
                OP_VTAKE: begin
                    r_slot  <= r_best_slot;
                    r_wsum  <= r_wsum - TOTAL_W'(r_best_w);
                    r_evict <= r_evict + EVICT_W'(1);
                end
                OP_SGOT: begin
                    if (r_rq == REQ_FIND) begin
                        r_fw <= cand_w;
                        r_fv <= cand_v;
                    end else begin
                        r_slot <= r_owner;
                        r_wsum <= r_wsum - TOTAL_W'(cand_w);
                    end
                end
                OP_DROP: begin
                    if (r_rv && r_ivalid[ra_i] && (idx_owner == r_slot)) begin
                        r_ivalid[ra_i] <= 1'b0;
                        r_icount       <= r_icount - ICNT_W'(1);
                    end
                end
                OP_DROP_END: begin
                    r_svalid[r_slot] <= 1'b0;
                    r_pkg_cnt        <= r_pkg_cnt - SCNT_W'(1);
                end
                OP_FINISH: begin
                    // hold the whole result while the next item runs
                    r_ostatus <= i_cmd.status;
                    r_ofw     <= r_fw;
                    r_ofv     <= r_fv;
                    r_ocount  <= PKG_COUNT_W'(r_pkg_cnt);
                    r_ototal  <= r_wsum;
                    r_oevict  <= r_evict;
                    if ((r_rq == REQ_PARK) && r_last) begin
                        r_stage_cnt <= '0;
                        r_conf      <= 1'b0;
                        r_ovf       <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // status toward the controller
    assign o_stat.rq        = r_rq;
    assign o_stat.last      = r_last;
    assign o_stat.hit       = r_hit;
    assign o_stat.scan_end  = (r_cnt >= lim) && !r_rv;
    assign o_stat.conflict  = r_conf;
    assign o_stat.overflow  = r_ovf;
    assign o_stat.idx_room  = CNT_W'(idx_free) >= CNT_W'(r_stage_cnt);
    assign o_stat.slot_end  = r_cnt >= CNT_W'(PACKAGE_SLOTS);
    assign o_stat.ins_wrote = !r_ivalid[cnt_i];
    assign o_stat.k_last    = (r_k + FCNT_W'(1)) == r_stage_cnt;
    assign o_stat.over_cap  = r_wsum > r_max_weight;
    assign o_stat.best_ok   = r_best_ok;
    assign o_stat.out_free  = !r_ovalid || i_out_ready;

    // result item
    assign o_out_valid     = r_ovalid;
    assign o_status        = r_ostatus;
    assign o_found_weight  = r_ofw;
    assign o_found_value   = r_ofv;
    assign o_package_count = r_ocount;
    assign o_total_weight  = r_ototal;
    assign o_evicted_total = r_oevict;

endmodule

// ===== src/disjoint_package_parking_table_unit.sv =====
// Parking table for packages of spent outpoints. Each input item is one
// outpoint with a request kind in tuser: park (tlast marks the footprint's
// final outpoint and carries weight and value), remove or find. Every item
// yields exactly one result item. Items are handled one at a time; the
// index, staging and slot stores are memories with one write and one read
// port, swept one entry per cycle. A find sweeps the index and a non-final
// park sweeps the index and the staging store; a remove adds one more
// index sweep. A final park adds the commit checks and slot allocation,
// index insertion, and a slot sweep and an index sweep for each package
// evicted over the weight cap. A finished result waits in an output
// register; the next item is taken as soon as the current one has been
// handed to that register.
// max_weight must be written on the config channel only while the block
// is idle; the block itself does not enforce this.
module disjoint_package_parking_table_unit #(
    parameter int INDEX_ENTRIES = dppt_pkg::INDEX_ENTRIES_DEF,
    parameter int PACKAGE_SLOTS = dppt_pkg::PACKAGE_SLOTS_DEF,
    parameter int FOOTPRINT_MAX = dppt_pkg::FOOTPRINT_MAX_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // txid_word0, txid_word1, txid_word2, txid_word3, out_position,
    // pkg_weight, pkg_value
    input  logic [dppt_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // req_type
    input  logic [dppt_pkg::REQ_W-1:0]        s_axis_tuser,
    input  logic                              s_axis_tlast,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // found_weight, found_value, package_count, total_weight, evicted_total
    output logic [dppt_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // status
    output logic [dppt_pkg::STATUS_W-1:0]     m_axis_tuser,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [dppt_pkg::TOTAL_W-1:0]      i_cfg_data
);
    import dppt_pkg::*;

    t_cmd                   cmd;
    t_stat                  stat;
    t_status                out_status;
    logic [WEIGHT_W-1:0]    found_weight;
    logic [VALUE_W-1:0]     found_value;
    logic [PKG_COUNT_W-1:0] package_count;
    logic [TOTAL_W-1:0]     total_weight;
    logic [EVICT_W-1:0]     evicted_total;

    dppt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    dppt_dp #(
        .INDEX_ENTRIES (INDEX_ENTRIES),
        .PACKAGE_SLOTS (PACKAGE_SLOTS),
        .FOOTPRINT_MAX (FOOTPRINT_MAX)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_req_type      (s_axis_tuser),
        .i_txid          (s_axis_tdata[TXID_W-1:0]),
        .i_out_position  (s_axis_tdata[TXID_W +: POS_W]),
        .i_last_input    (s_axis_tlast),
        .i_pkg_weight    (s_axis_tdata[KEY_W +: WEIGHT_W]),
        .i_pkg_value     (s_axis_tdata[KEY_W+WEIGHT_W +: VALUE_W]),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_data      (i_cfg_data),
        .i_out_ready     (m_axis_tready),
        .o_out_valid     (m_axis_tvalid),
        .o_status        (out_status),
        .o_found_weight  (found_weight),
        .o_found_value   (found_value),
        .o_package_count (package_count),
        .o_total_weight  (total_weight),
        .o_evicted_total (evicted_total)
    );

    // result packing, lowest field first
    assign m_axis_tuser = out_status;
    assign m_axis_tdata = {2'b00, evicted_total, total_weight, package_count,
                           found_value, found_weight};
    assign o_cfg_ready  = 1'b1;

endmodule
